/* sv/kdv_pkg.sv */
// Shared types, constants and tables for the kick drum voice.
// Depends on nothing; used by kdv_ctrl, kdv_datapath and the top level.
package kdv_pkg;

   localparam int SINE_TABLE_SIZE = 1024;
   localparam int SINE_BITS       = $clog2(SINE_TABLE_SIZE);
   localparam int IDX_PROD_W      = 32 + SINE_BITS + 1;

   // input opcode
   localparam logic OP_TICK    = 1'b0;
   localparam logic OP_TRIGGER = 1'b1;

   // register indexes
   localparam logic [2:0] REG_TUNE       = 3'd0;
   localparam logic [2:0] REG_DECAY      = 3'd1;
   localparam logic [2:0] REG_PUNCH      = 3'd2;
   localparam logic [2:0] REG_DRIVE      = 3'd3;
   localparam logic [2:0] REG_PHASE_STEP = 3'd4;

   localparam logic [7:0]  TUNE_RST       = 8'd128;
   localparam logic [7:0]  DECAY_RST      = 8'd102;
   localparam logic [7:0]  PUNCH_RST      = 8'd128;
   localparam logic [7:0]  DRIVE_RST      = 8'd0;
   localparam logic [23:0] PHASE_STEP_RST = 24'd89478;

   // sequencer steps (also the controller state codes)
   localparam logic [4:0] ST_IDLE    = 5'd0;
   localparam logic [4:0] ST_GAIN    = 5'd1;
   localparam logic [4:0] ST_PITCH   = 5'd2;
   localparam logic [4:0] ST_PE2     = 5'd3;
   localparam logic [4:0] ST_FREQ    = 5'd4;
   localparam logic [4:0] ST_PHASE   = 5'd5;
   localparam logic [4:0] ST_ROM     = 5'd6;
   localparam logic [4:0] ST_CUBE1   = 5'd7;
   localparam logic [4:0] ST_CUBE2   = 5'd8;
   localparam logic [4:0] ST_CLICK1  = 5'd9;
   localparam logic [4:0] ST_CLICK2  = 5'd10;
   localparam logic [4:0] ST_DRIVE   = 5'd11;
   localparam logic [4:0] ST_CLIP1   = 5'd12;
   localparam logic [4:0] ST_CLIP2   = 5'd13;
   localparam logic [4:0] ST_CLIP3   = 5'd14;
   localparam logic [4:0] ST_GAINAPP = 5'd15;
   localparam logic [4:0] ST_FC      = 5'd16;
   localparam logic [4:0] ST_QBP     = 5'd17;
   localparam logic [4:0] ST_BP      = 5'd18;
   localparam logic [4:0] ST_LP      = 5'd19;
   localparam logic [4:0] ST_DC      = 5'd20;
   localparam logic [4:0] ST_OUT     = 5'd21;

   // fixed-point constants
   localparam logic [23:0]        ENV_FULL    = 24'hFFFFFF;
   localparam logic [23:0]        ENV_FLOOR   = 24'd16777;
   localparam logic [23:0]        PITCH_MUL   = 24'd16106127;
   localparam logic [23:0]        SOFT_CLIP_K = 24'd621176;
   localparam logic [23:0]        FC_PITCH_K  = 24'd419430;
   localparam logic [23:0]        DC_POLE     = 24'd4173332;
   localparam logic [21:0]        FC_MAX      = 22'd3774874;
   localparam logic signed [27:0] CLIP_KNEE   = 28'sd6291456;
   localparam logic signed [23:0] Q22_ONE     = 24'sd4194304;

   typedef struct packed {
      logic [23:0] gain_mul;
      logic [22:0] freq_base;
      logic [24:0] sweep;
      logic [21:0] level;
      logic [21:0] q;
      logic [24:0] drive_gain;
      logic [19:0] fc_base;
      logic [23:0] phase_step;
   } coef_type;

   typedef struct packed {
      logic [4:0] step;
      logic       load_trig;
      logic       zero_res;
   } dp_cmd_type;

   typedef struct packed {
      logic voice_on;
      logic gain_low;
      logic click_live;
   } dp_status_type;

   // coefficient tables, one entry per 8-bit register value
   localparam int TAB_GAIN  = 0;
   localparam int TAB_FREQ  = 1;
   localparam int TAB_SWEEP = 2;
   localparam int TAB_LEVEL = 3;
   localparam int TAB_Q     = 4;
   localparam int TAB_DRIVE = 5;
   localparam int TAB_FC    = 6;

   typedef logic [25:0] coef_tab_type [256];

   function automatic coef_tab_type build_tab(input int sel);
      coef_tab_type tab;
      longint       v;
      longint       n;
      for (int i = 0; i < 256; i++) begin
         n = longint'(i);
         case (sel)
            TAB_GAIN:  v = 16777216 - 4194 - ((255 - n) * 33554) / 255;
            TAB_FREQ:  v = 2293760 + (n * 3276800) / 255;
            TAB_SWEEP: v = 9830400 + (n * 22937600) / 255;
            TAB_LEVEL: v = 419430 + (n * 1677722) / 255;
            TAB_Q:     v = 2097152 + (n * 1677722) / 255;
            TAB_DRIVE: v = 4194304 + (n * 16777216) / 255;
            TAB_FC:    v = 335544 + (n * 671089) / 255;
            default:   v = 0;
         endcase
         tab[i] = 26'(v);
      end
      return tab;
   endfunction

   localparam coef_tab_type GAIN_MUL_TAB  = build_tab(TAB_GAIN);
   localparam coef_tab_type FREQ_BASE_TAB = build_tab(TAB_FREQ);
   localparam coef_tab_type SWEEP_TAB     = build_tab(TAB_SWEEP);
   localparam coef_tab_type LEVEL_TAB     = build_tab(TAB_LEVEL);
   localparam coef_tab_type Q_TAB         = build_tab(TAB_Q);
   localparam coef_tab_type DRIVE_TAB     = build_tab(TAB_DRIVE);
   localparam coef_tab_type FC_BASE_TAB   = build_tab(TAB_FC);

   // sine ROM: quadrant fold, then Taylor series to x^13 in Q30
   typedef logic signed [15:0] sine_tab_type [SINE_TABLE_SIZE];

   function automatic logic signed [15:0] sine_entry(input longint unsigned i);
      longint unsigned one;
      longint unsigned u;
      longint unsigned r;
      longint unsigned f;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned s;
      longint unsigned v;
      logic [1:0]      quad;
      one  = 64'd1 << 30;
      u    = (i << 32) / SINE_TABLE_SIZE;
      quad = 2'(u >> 30);
      r    = u & (one - 64'd1);
      f    = quad[0] ? (one - r) : r;
      x    = (f * 64'd1686629713) >> 30;
      x2   = (x * x) >> 30;
      t    = one;
      t    = one - (((x2 * t) / 156) >> 30);
      t    = one - (((x2 * t) / 110) >> 30);
      t    = one - (((x2 * t) / 72) >> 30);
      t    = one - (((x2 * t) / 42) >> 30);
      t    = one - (((x2 * t) / 20) >> 30);
      t    = one - (((x2 * t) / 6) >> 30);
      s    = (x * t) >> 30;
      v    = (s * 64'd32767 + (one >> 1)) >> 30;
      if (v > 64'd32767) v = 64'd32767;
      return quad[1] ? -16'(v) : 16'(v);
   endfunction

   function automatic sine_tab_type build_sine_rom();
      sine_tab_type tab;
      for (int i = 0; i < SINE_TABLE_SIZE; i++) begin
         tab[i] = sine_entry(longint'(i));
      end
      return tab;
   endfunction

   localparam sine_tab_type SINE_ROM = build_sine_rom();

endpackage

/* sv/kdv_ctrl.sv */
// Sequencer for the kick drum voice: walks one tick through the datapath steps.
// Depends on kdv_pkg.
module kdv_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_opcode,
   output logic                   req_ready,
   input  logic                   out_free,
   output logic                   out_load,
   input  kdv_pkg::dp_status_type status,
   output kdv_pkg::dp_cmd_type    cmd
);
   import kdv_pkg::*;

   logic [4:0] state_ff;
   logic [4:0] state_in;
   logic       take;

   assign req_ready = (state_ff == ST_IDLE);
   assign take      = req_valid && req_ready;
   assign out_load  = (state_ff == ST_OUT) && out_free;

   always_comb begin
      cmd.step      = state_ff;
      cmd.load_trig = take && (req_opcode == OP_TRIGGER);
      cmd.zero_res  = take && (req_opcode == OP_TICK) && !status.voice_on;
      state_in      = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take && req_opcode == OP_TICK)
               state_in = status.voice_on ? ST_GAIN : ST_OUT;
         end
         ST_GAIN:    state_in = ST_PITCH;
         ST_PITCH:   state_in = ST_PE2;
         ST_PE2:     state_in = status.gain_low ? ST_OUT : ST_FREQ;
         ST_FREQ:    state_in = ST_PHASE;
         ST_PHASE:   state_in = ST_ROM;
         ST_ROM:     state_in = ST_CUBE1;
         ST_CUBE1:   state_in = ST_CUBE2;
         ST_CUBE2:   state_in = status.click_live ? ST_CLICK1 : ST_DRIVE;
         ST_CLICK1:  state_in = ST_CLICK2;
         ST_CLICK2:  state_in = ST_DRIVE;
         ST_DRIVE:   state_in = ST_CLIP1;
         ST_CLIP1:   state_in = ST_CLIP2;
         ST_CLIP2:   state_in = ST_CLIP3;
         ST_CLIP3:   state_in = ST_GAINAPP;
         ST_GAINAPP: state_in = ST_FC;
         ST_FC:      state_in = ST_QBP;
         ST_QBP:     state_in = ST_BP;
         ST_BP:      state_in = ST_LP;
         ST_LP:      state_in = ST_DC;
         ST_DC:      state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

/* sv/kdv_datapath.sv */
// Datapath of the kick drum voice: voice state, one shared 28x28 multiplier, sine ROM.
// Depends on kdv_pkg; driven step by step from kdv_ctrl.
module kdv_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  kdv_pkg::dp_cmd_type    cmd,
   input  kdv_pkg::coef_type      coef,
   input  logic [15:0]            velocity,
   output kdv_pkg::dp_status_type status,
   output logic signed [15:0]     res_sample,
   output logic                   res_active
);
   import kdv_pkg::*;

   function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
      if (v > 28'sd8388607)       return 24'sd8388607;
      else if (v < -28'sd8388608) return -24'sd8388608;
      else                        return 24'(v);
   endfunction

   // voice state
   logic               voice_ff, voice_in;
   logic [23:0]        gain_ff, gain_in;
   logic [23:0]        pitch_ff, pitch_in;
   logic [23:0]        click_ff, click_in;
   logic [31:0]        phase_ff, phase_in;
   logic signed [23:0] lp_ff, lp_in;
   logic signed [23:0] bp_ff, bp_in;
   logic signed [23:0] dci_ff, dci_in;
   logic signed [23:0] dco_ff, dco_in;
   // per-tick temporaries
   logic [23:0]        pe2_ff, pe2_in;
   logic [25:0]        freq_ff, freq_in;
   logic signed [15:0] rom_ff;
   logic signed [23:0] sq_ff, sq_in;
   logic signed [26:0] shaped_ff, shaped_in;
   logic signed [23:0] tmp_ff, tmp_in;
   logic signed [27:0] driven_ff, driven_in;
   logic signed [27:0] d2_ff, d2_in;
   logic signed [27:0] d3_ff, d3_in;
   logic signed [23:0] clipped_ff, clipped_in;
   logic signed [23:0] x_ff, x_in;
   logic [21:0]        fc_ff, fc_in;
   logic signed [26:0] hp_ff, hp_in;
   logic signed [15:0] sample_ff, sample_in;
   logic               active_ff, active_in;

   logic signed [27:0] mul_a, mul_b;
   logic signed [55:0] prod, p16, p22, p23, p24;
   logic signed [22:0] s_val;
   logic signed [32:0] saw_full;
   logic [24:0]        vel_ext;
   logic [IDX_PROD_W-1:0] idx_prod;
   logic [SINE_BITS-1:0]  rom_idx;
   logic [22:0]        fc_sum;
   logic signed [27:0] bp_sum, lp_sum, dc_sum;
   logic signed [23:0] dc_y;
   logic signed [16:0] dc_scaled;

   assign s_val    = {rom_ff, 7'b0};
   assign saw_full = 33'sd2147483648 - signed'({1'b0, phase_ff});
   assign vel_ext  = {velocity, 9'b0};
   assign idx_prod = IDX_PROD_W'(phase_ff) * IDX_PROD_W'(SINE_TABLE_SIZE);
   assign rom_idx  = idx_prod[32 +: SINE_BITS];

   assign status.voice_on   = voice_ff;
   assign status.gain_low   = gain_ff < ENV_FLOOR;
   assign status.click_live = click_ff > ENV_FLOOR;
   assign res_sample        = sample_ff;
   assign res_active        = active_ff;

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.step)
         ST_GAIN:    begin mul_a = 28'(gain_ff);        mul_b = 28'(coef.gain_mul);   end
         ST_PITCH:   begin mul_a = 28'(pitch_ff);       mul_b = 28'(PITCH_MUL);       end
         ST_PE2:     begin mul_a = 28'(pitch_ff);       mul_b = 28'(pitch_ff);        end
         ST_FREQ:    begin mul_a = 28'(coef.sweep);     mul_b = 28'(pe2_ff);          end
         ST_PHASE:   begin mul_a = 28'(freq_ff);        mul_b = 28'(coef.phase_step); end
         ST_CUBE1:   begin mul_a = 28'(s_val);          mul_b = 28'(s_val);           end
         ST_CUBE2:   begin mul_a = 28'(s_val);          mul_b = 28'(sq_ff);           end
         ST_CLICK1:  begin
            mul_a = 28'(click_ff);
            mul_b = 28'(signed'(saw_full[32:9]));
         end
         ST_CLICK2:  begin mul_a = 28'(tmp_ff);         mul_b = 28'(coef.level);      end
         ST_DRIVE:   begin mul_a = 28'(shaped_ff);      mul_b = 28'(coef.drive_gain); end
         ST_CLIP1:   begin mul_a = driven_ff;           mul_b = driven_ff;            end
         ST_CLIP2:   begin mul_a = driven_ff;           mul_b = d2_ff;                end
         ST_CLIP3:   begin mul_a = d3_ff;               mul_b = 28'(SOFT_CLIP_K);     end
         ST_GAINAPP: begin mul_a = 28'(clipped_ff);     mul_b = 28'(gain_ff);         end
         ST_FC:      begin mul_a = 28'(pe2_ff);         mul_b = 28'(FC_PITCH_K);      end
         ST_QBP:     begin mul_a = 28'(coef.q);         mul_b = 28'(bp_ff);           end
         ST_BP:      begin mul_a = 28'(fc_ff);          mul_b = 28'(hp_ff);           end
         ST_LP:      begin mul_a = 28'(fc_ff);          mul_b = 28'(bp_ff);           end
         ST_DC:      begin mul_a = 28'(DC_POLE);        mul_b = 28'(dco_ff);          end
         default: ;
      endcase
   end

   assign prod = mul_a * mul_b;
   assign p16  = prod >>> 16;
   assign p22  = prod >>> 22;
   assign p23  = prod >>> 23;
   assign p24  = prod >>> 24;

   assign fc_sum    = 23'(coef.fc_base) + p24[22:0];
   assign bp_sum    = 28'(bp_ff) + signed'(p22[27:0]);
   assign lp_sum    = 28'(lp_ff) + signed'(p22[27:0]);
   assign dc_sum    = 28'(lp_ff) - 28'(dci_ff) + signed'(p22[27:0]);
   assign dc_y      = sat24(dc_sum);
   assign dc_scaled = 17'(dc_y >>> 7);

   always_comb begin
      voice_in   = voice_ff;
      gain_in    = gain_ff;
      pitch_in   = pitch_ff;
      click_in   = click_ff;
      phase_in   = phase_ff;
      lp_in      = lp_ff;
      bp_in      = bp_ff;
      dci_in     = dci_ff;
      dco_in     = dco_ff;
      pe2_in     = pe2_ff;
      freq_in    = freq_ff;
      sq_in      = sq_ff;
      shaped_in  = shaped_ff;
      tmp_in     = tmp_ff;
      driven_in  = driven_ff;
      d2_in      = d2_ff;
      d3_in      = d3_ff;
      clipped_in = clipped_ff;
      x_in       = x_ff;
      fc_in      = fc_ff;
      hp_in      = hp_ff;
      sample_in  = sample_ff;
      active_in  = active_ff;
      case (cmd.step)
         ST_IDLE: begin
            if (cmd.load_trig) begin
               gain_in  = vel_ext[24] ? ENV_FULL : vel_ext[23:0];
               pitch_in = ENV_FULL;
               click_in = ENV_FULL;
               phase_in = '0;
               voice_in = 1'b1;
            end
            if (cmd.zero_res) begin
               sample_in = '0;
               active_in = 1'b0;
            end
         end
         ST_GAIN:  gain_in  = p24[23:0];
         ST_PITCH: pitch_in = p24[23:0];
         ST_PE2: begin
            // voice ends here when the decayed gain drops under the floor
            if (status.gain_low) begin
               voice_in  = 1'b0;
               sample_in = '0;
               active_in = 1'b0;
            end else begin
               pe2_in = p24[23:0];
            end
         end
         ST_FREQ:   freq_in   = 26'(coef.freq_base) + p24[25:0];
         ST_PHASE:  phase_in  = phase_ff + p16[31:0];
         ST_CUBE1:  sq_in     = p22[23:0];
         ST_CUBE2:  shaped_in = 27'(s_val) + p23[26:0];
         ST_CLICK1: tmp_in    = p24[23:0];
         ST_CLICK2: begin
            shaped_in = shaped_ff + p22[26:0];
            click_in  = click_ff >> 1;
         end
         ST_DRIVE:  driven_in = p22[27:0];
         ST_CLIP1:  d2_in     = p22[27:0];
         ST_CLIP2:  d3_in     = p22[27:0];
         ST_CLIP3: begin
            if (driven_ff > CLIP_KNEE)       clipped_in = Q22_ONE;
            else if (driven_ff < -CLIP_KNEE) clipped_in = -Q22_ONE;
            else clipped_in = 24'(driven_ff - signed'(p22[27:0]));
         end
         ST_GAINAPP: x_in = p24[23:0];
         ST_FC:      fc_in = (fc_sum > 23'(FC_MAX)) ? FC_MAX : fc_sum[21:0];
         ST_QBP:     hp_in = 27'(x_ff) - 27'(lp_ff) - signed'(p22[26:0]);
         ST_BP:      bp_in = sat24(bp_sum);
         ST_LP:      lp_in = sat24(lp_sum);
         ST_DC: begin
            dci_in    = lp_ff;
            dco_in    = dc_y;
            active_in = 1'b1;
            if (dc_scaled > 17'sd32767)       sample_in = 16'sd32767;
            else if (dc_scaled < -17'sd32768) sample_in = -16'sd32768;
            else                              sample_in = 16'(dc_scaled);
         end
         default: ;
      endcase
   end

   // sine ROM, registered read
   always_ff @(posedge clock) begin
      if (cmd.step == ST_ROM) rom_ff <= SINE_ROM[rom_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         voice_ff <= 1'b0;
         gain_ff  <= '0;
         pitch_ff <= '0;
         click_ff <= '0;
         phase_ff <= '0;
         lp_ff    <= '0;
         bp_ff    <= '0;
         dci_ff   <= '0;
         dco_ff   <= '0;
      end else begin
         voice_ff <= voice_in;
         gain_ff  <= gain_in;
         pitch_ff <= pitch_in;
         click_ff <= click_in;
         phase_ff <= phase_in;
         lp_ff    <= lp_in;
         bp_ff    <= bp_in;
         dci_ff   <= dci_in;
         dco_ff   <= dco_in;
      end
   end

   always_ff @(posedge clock) begin
      pe2_ff     <= pe2_in;
      freq_ff    <= freq_in;
      sq_ff      <= sq_in;
      shaped_ff  <= shaped_in;
      tmp_ff     <= tmp_in;
      driven_ff  <= driven_in;
      d2_ff      <= d2_in;
      d3_ff      <= d3_in;
      clipped_ff <= clipped_in;
      x_ff       <= x_in;
      fc_ff      <= fc_in;
      hp_ff      <= hp_in;
      sample_ff  <= sample_in;
      active_ff  <= active_in;
   end

endmodule

/* sv/kick_drum_voice_synth_core.sv */
// Kick drum voice top level: register port, sequencer, datapath, result register.
// Trigger: taken while idle, loads the voice state, no result. A tick with the voice off goes
// straight to the result; one on which the voice dies ends after ST_PE2; one that sounds runs
// every step, ST_CLICK1/2 too while the click runs. The next transaction waits for the result
// load and any result-side stall; one item at a time, set by the single shared 28x28 multiplier.
// Reset (synchronous) silences the voice, zeroes the voice state and loads register defaults.
module kick_drum_voice_synth_core (
   input  logic               clock,
   input  logic               reset,
   // input stream
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [15:0]        req_tdata,   // [15:0] velocity
   input  logic               req_tuser,   // [0] opcode
   // result stream
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic signed [15:0] rsp_tdata,   // [15:0] sample
   output logic               rsp_tuser,   // [0] voice_active
   // register port
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import kdv_pkg::*;

   // raw registers and the coefficients derived from them
   logic [7:0]  tune_ff, decay_ff, punch_ff, drive_ff;
   logic [23:0] step_ff;
   coef_type    coef_ff;
   logic        csr_wr;
   logic [2:0]  csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[4:2];

   // coefficients come from per-register tables at write time, so the
   // datapath never divides
   always_ff @(posedge clock) begin
      if (reset) begin
         tune_ff                 <= TUNE_RST;
         decay_ff                <= DECAY_RST;
         punch_ff                <= PUNCH_RST;
         drive_ff                <= DRIVE_RST;
         step_ff                 <= PHASE_STEP_RST;
         coef_ff.freq_base       <= FREQ_BASE_TAB[TUNE_RST][22:0];
         coef_ff.gain_mul        <= GAIN_MUL_TAB[DECAY_RST][23:0];
         coef_ff.sweep           <= SWEEP_TAB[PUNCH_RST][24:0];
         coef_ff.level           <= LEVEL_TAB[PUNCH_RST][21:0];
         coef_ff.q               <= Q_TAB[PUNCH_RST][21:0];
         coef_ff.drive_gain      <= DRIVE_TAB[DRIVE_RST][24:0];
         coef_ff.fc_base         <= FC_BASE_TAB[DRIVE_RST][19:0];
         coef_ff.phase_step      <= PHASE_STEP_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_TUNE: begin
               tune_ff           <= csr_pwdata[7:0];
               coef_ff.freq_base <= FREQ_BASE_TAB[csr_pwdata[7:0]][22:0];
            end
            REG_DECAY: begin
               decay_ff         <= csr_pwdata[7:0];
               coef_ff.gain_mul <= GAIN_MUL_TAB[csr_pwdata[7:0]][23:0];
            end
            REG_PUNCH: begin
               punch_ff      <= csr_pwdata[7:0];
               coef_ff.sweep <= SWEEP_TAB[csr_pwdata[7:0]][24:0];
               coef_ff.level <= LEVEL_TAB[csr_pwdata[7:0]][21:0];
               coef_ff.q     <= Q_TAB[csr_pwdata[7:0]][21:0];
            end
            REG_DRIVE: begin
               drive_ff           <= csr_pwdata[7:0];
               coef_ff.drive_gain <= DRIVE_TAB[csr_pwdata[7:0]][24:0];
               coef_ff.fc_base    <= FC_BASE_TAB[csr_pwdata[7:0]][19:0];
            end
            REG_PHASE_STEP: begin
               step_ff            <= csr_pwdata[23:0];
               coef_ff.phase_step <= csr_pwdata[23:0];
            end
            default: ;  // addresses past the register list are ignored
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_TUNE:       csr_prdata = 32'(tune_ff);
         REG_DECAY:      csr_prdata = 32'(decay_ff);
         REG_PUNCH:      csr_prdata = 32'(punch_ff);
         REG_DRIVE:      csr_prdata = 32'(drive_ff);
         REG_PHASE_STEP: csr_prdata = 32'(step_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // sequencer and datapath
   dp_cmd_type         cmd;
   dp_status_type      status;
   logic               out_free;
   logic               out_load;
   logic signed [15:0] res_sample;
   logic               res_active;

   kdv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_opcode (req_tuser),
      .req_ready  (req_tready),
      .out_free   (out_free),
      .out_load   (out_load),
      .status     (status),
      .cmd        (cmd)
   );

   kdv_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .coef       (coef_ff),
      .velocity   (req_tdata),
      .status     (status),
      .res_sample (res_sample),
      .res_active (res_active)
   );

   // result register: holds one finished transaction while the sink stalls
   logic               rsp_valid_ff;
   logic signed [15:0] rsp_sample_ff;
   logic               rsp_active_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset)          rsp_valid_ff <= 1'b0;
      else if (out_load)  rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_sample_ff <= res_sample;
         rsp_active_ff <= res_active;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_sample_ff;
   assign rsp_tuser  = rsp_active_ff;

`ifndef SYNTHESIS
   // a silent voice always reports a zero sample
   a_silent_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == 16'sd0))
      else $error("inactive result with nonzero sample");

   // a trigger completes in the cycle it is taken
   a_trig_fast: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == OP_TRIGGER) |=> req_tready)
      else $error("trigger did not return to idle");

   // a tick closes the input once it is taken
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == OP_TICK) |=> !req_tready)
      else $error("input reopened during a tick");
`endif

endmodule
